// ----- sv/rcfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the receiver frame decoder.
// No dependencies; every other file imports this package.

package rcfd_pkg;

    localparam int FRAME_BYTES   = 18;
    localparam int BUFFER_FRAMES = 2;
    localparam int BUF_BYTES     = FRAME_BYTES * BUFFER_FRAMES;
    localparam int ADDR_W        = $clog2(BUF_BYTES);
    localparam int COUNT_W       = $clog2(BUF_BYTES + 1);
    localparam int FRAMES_W      = $clog2(BUFFER_FRAMES + 1);
    localparam int BYTE_IDX_W    = $clog2(FRAME_BYTES + 1);

    localparam int NUM_CH  = 5;
    localparam int CH_W    = 11;
    localparam int MID_W   = 11;
    localparam int LIM_W   = 10;
    localparam int TMO_W   = 16;
    localparam int NEED_W  = 3;
    localparam int TIME_W  = 32;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [MID_W-1:0]  MIDPOINT_RST = 11'd1024;
    localparam logic [LIM_W-1:0]  LIMIT_RST    = 10'd700;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd100;
    localparam logic [NEED_W-1:0] NEEDED_RST   = 3'd5;

    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_IDLE     = 2'd1,
        OP_TICK     = 2'd2,
        OP_UART_ERR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_TICK      = 3'd0,
        ST_ACCEPT    = 3'd1,
        ST_REJECT    = 3'd2,
        ST_BURST_BAD = 3'd3,
        ST_UART_ERR  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_MIDPOINT = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_TIMEOUT  = 2'd2,
        REG_NEEDED   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MID_W-1:0]  midpoint;
        logic [LIM_W-1:0]  limit;
        logic [TMO_W-1:0]  timeout;
        logic [NEED_W-1:0] needed;
    } cfg_t;

    typedef struct packed {
        logic              byte_wr;
        logic              burst_clear;
        logic              tick;
        logic              run_clear;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              shift_en;
        logic              commit;
        logic              emit;
        status_t           status;
    } dp_cmd_t;

    typedef struct packed {
        logic                burst_empty;
        logic                burst_last;
        logic [FRAMES_W-1:0] burst_frames;
        logic                frame_bad;
        logic                out_busy;
    } dp_stat_t;

endpackage

// ----- sv/rcfd_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers of the receiver frame decoder.
// Depends on rcfd_pkg.

module rcfd_regs
    import rcfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MIDPOINT: cfg_next.midpoint = pwdata[MID_W-1:0];
                REG_LIMIT:    cfg_next.limit    = pwdata[LIM_W-1:0];
                REG_TIMEOUT:  cfg_next.timeout  = pwdata[TMO_W-1:0];
                REG_NEEDED:   cfg_next.needed   = pwdata[NEED_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIDPOINT: prdata = PDATA_W'(cfg_reg.midpoint);
            REG_LIMIT:    prdata = PDATA_W'(cfg_reg.limit);
            REG_TIMEOUT:  prdata = PDATA_W'(cfg_reg.timeout);
            REG_NEEDED:   prdata = PDATA_W'(cfg_reg.needed);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midpoint <= MIDPOINT_RST;
            cfg_reg.limit    <= LIMIT_RST;
            cfg_reg.timeout  <= TIMEOUT_RST;
            cfg_reg.needed   <= NEEDED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/rcfd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the receiver frame decoder: input handshake, burst sequencing
// and result emission. Depends on rcfd_pkg; drives rcfd_datapath by commands.

module rcfd_ctrl
    import rcfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  op_t      op,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_CHECK = 5'b01000,
        S_EMIT  = 5'b10000
    } fsm_state_t;

    fsm_state_t              state_reg,       state_next;
    logic [BYTE_IDX_W-1:0]   cnt_reg,         cnt_next;
    logic [ADDR_W-1:0]       base_reg,        base_next;
    logic [FRAMES_W-1:0]     frames_left_reg, frames_left_next;
    status_t                 status_reg,      status_next;
    logic                    accept;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        base_next        = base_reg;
        frames_left_next = frames_left_reg;
        status_next      = status_reg;
        cmd              = '0;
        cmd.status       = status_reg;
        cmd.rd_addr      = base_reg + ADDR_W'(cnt_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_BYTE:
                        begin
                            cmd.byte_wr = 1'b1;
                            if (stat.burst_last)
                                state_next = S_EVAL;
                        end
                        OP_IDLE:
                        begin
                            if (!stat.burst_empty)
                                state_next = S_EVAL;
                        end
                        OP_TICK:
                        begin
                            cmd.tick         = 1'b1;
                            status_next      = ST_TICK;
                            frames_left_next = FRAMES_W'(1);
                            state_next       = S_EMIT;
                        end
                        OP_UART_ERR:
                        begin
                            cmd.burst_clear  = 1'b1;
                            cmd.run_clear    = 1'b1;
                            status_next      = ST_UART_ERR;
                            frames_left_next = FRAMES_W'(1);
                            state_next       = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_EVAL:
            begin
                cmd.burst_clear = 1'b1;
                if (stat.burst_frames == '0)
                begin
                    cmd.run_clear    = 1'b1;
                    status_next      = ST_BURST_BAD;
                    frames_left_next = FRAMES_W'(1);
                    state_next       = S_EMIT;
                end
                else
                begin
                    frames_left_next = stat.burst_frames;
                    base_next        = '0;
                    cnt_next         = '0;
                    state_next       = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // read data is registered, so it arrives in the cycle after its address
                cmd.rd_en    = (cnt_reg < BYTE_IDX_W'(FRAME_BYTES));
                cmd.shift_en = (cnt_reg != '0);
                if (cnt_reg == BYTE_IDX_W'(FRAME_BYTES))
                    state_next = S_CHECK;
                else
                    cnt_next = cnt_reg + BYTE_IDX_W'(1);
            end

            S_CHECK:
            begin
                cmd.commit  = 1'b1;
                status_next = stat.frame_bad ? ST_REJECT : ST_ACCEPT;
                state_next  = S_EMIT;
            end

            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit = 1'b1;
                    if (frames_left_reg == FRAMES_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        frames_left_next = frames_left_reg - FRAMES_W'(1);
                        base_next        = base_reg + ADDR_W'(FRAME_BYTES);
                        cnt_next         = '0;
                        state_next       = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            base_reg        <= '0;
            frames_left_reg <= '0;
            status_reg      <= ST_TICK;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            base_reg        <= base_next;
            frames_left_reg <= frames_left_next;
            status_reg      <= status_next;
        end
    end

endmodule

// ----- sv/rcfd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the receiver frame decoder: byte buffer, frame register, checks,
// stored frame, link timers and the output register. Depends on rcfd_pkg.

module rcfd_datapath
    import rcfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  dp_cmd_t                 cmd,
    input  logic [7:0]              data_byte,
    output dp_stat_t                stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CH_W-1:0]  stick_ch0,
    output logic signed [CH_W-1:0]  stick_ch1,
    output logic signed [CH_W-1:0]  stick_ch2,
    output logic signed [CH_W-1:0]  stick_ch3,
    output logic signed [CH_W-1:0]  wheel_ch4,
    output logic [3:0]              switch_pair,
    output logic signed [15:0]      mouse_dx,
    output logic signed [15:0]      mouse_dy,
    output logic signed [15:0]      mouse_dz,
    output logic [17:0]             keys_and_buttons,
    output logic [2:0]              status,
    output logic [1:0]              link_flags
);

    // byte buffer
    logic [7:0]          mem [BUF_BYTES];
    logic [7:0]          rd_data_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // frame being checked, byte 0 at index 0 after a full load
    logic [7:0]          frame_reg [FRAME_BYTES];

    // stored frame and link state
    logic signed [CH_W-1:0] stick_reg [NUM_CH];
    logic [3:0]             switch_reg;
    logic [15:0]            mouse_reg [3];
    logic [17:0]            keys_reg;
    logic [NEED_W-1:0]      run_reg,  run_next;
    logic [TIME_W-1:0]      seq_reg;
    logic [TIME_W-1:0]      last_acc_reg;
    logic [TIME_W-1:0]      time_reg;

    // output register
    logic                   out_valid_reg;
    logic signed [CH_W-1:0] out_stick_reg [NUM_CH];
    logic [3:0]             out_switch_reg;
    logic [15:0]            out_mouse_reg [3];
    logic [17:0]            out_keys_reg;
    logic [2:0]             out_status_reg;
    logic [1:0]             out_link_reg;

    // decode
    logic [CH_W-1:0]        raw [NUM_CH];
    logic signed [CH_W:0]   centred [NUM_CH];
    logic signed [CH_W:0]   lim_pos;
    logic signed [CH_W:0]   lim_neg;
    logic                   ch_bad;
    logic [1:0]             sw_one;
    logic [1:0]             sw_two;
    logic                   frame_bad;
    logic                   accept_frame;
    logic [TIME_W-1:0]      age;
    logic [1:0]             link_now;
    logic [FRAMES_W-1:0]    frames;

    always_comb
    begin
        raw[0] = {frame_reg[1][2:0], frame_reg[0]};
        raw[1] = {frame_reg[2][5:0], frame_reg[1][7:3]};
        raw[2] = {frame_reg[4][0], frame_reg[3], frame_reg[2][7:6]};
        raw[3] = {frame_reg[5][3:0], frame_reg[4][7:1]};
        raw[4] = {frame_reg[17][2:0], frame_reg[16]};
    end

    assign lim_pos = $signed((CH_W + 1)'(cfg.limit));
    assign lim_neg = -lim_pos;
    assign sw_one  = frame_reg[5][5:4];
    assign sw_two  = frame_reg[5][7:6];

    always_comb
    begin
        ch_bad = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            centred[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.midpoint});
            if ((centred[i] > lim_pos) || (centred[i] < lim_neg))
                ch_bad = 1'b1;
        end
    end

    assign frame_bad = ch_bad || (sw_one == 2'd0) || (sw_two == 2'd0)
                       || (frame_reg[12][7:1] != '0) || (frame_reg[13][7:1] != '0);
    assign accept_frame = cmd.commit && !frame_bad;

    // burst length in whole frames, zero when it is not a multiple
    always_comb
    begin
        frames = '0;
        for (int k = 1; k <= BUFFER_FRAMES; k++)
        begin
            if (count_reg == COUNT_W'(k * FRAME_BYTES))
                frames = FRAMES_W'(k);
        end
    end

    assign age      = time_reg - last_acc_reg;
    assign link_now = {(run_reg >= cfg.needed),
                       (seq_reg != '0) && (age <= TIME_W'(cfg.timeout))};

    assign stat.burst_empty  = (count_reg == '0);
    assign stat.burst_last   = (count_reg == COUNT_W'(BUF_BYTES - 1));
    assign stat.burst_frames = frames;
    assign stat.frame_bad    = frame_bad;
    assign stat.out_busy     = out_valid_reg && !out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.burst_clear)
            count_next = '0;
        else if (cmd.byte_wr)
            count_next = count_reg + COUNT_W'(1);
    end

    always_comb
    begin
        run_next = run_reg;
        if (cmd.run_clear || (cmd.commit && frame_bad))
            run_next = '0;
        else if (accept_frame && (run_reg < cfg.needed))
            run_next = run_reg + NEED_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr)
            mem[count_reg[ADDR_W-1:0]] <= data_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            for (int i = 0; i < FRAME_BYTES - 1; i++)
                frame_reg[i] <= frame_reg[i + 1];
            frame_reg[FRAME_BYTES - 1] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            run_reg      <= '0;
            seq_reg      <= '0;
            last_acc_reg <= '0;
            time_reg     <= '0;
            for (int i = 0; i < NUM_CH; i++)
                stick_reg[i] <= '0;
            switch_reg   <= '0;
            for (int i = 0; i < 3; i++)
                mouse_reg[i] <= '0;
            keys_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg   <= run_next;
            if (cmd.tick)
                time_reg <= time_reg + TIME_W'(1);
            if (accept_frame)
            begin
                for (int i = 0; i < NUM_CH; i++)
                    stick_reg[i] <= centred[i][CH_W-1:0];
                switch_reg   <= {sw_two, sw_one};
                mouse_reg[0] <= {frame_reg[7], frame_reg[6]};
                mouse_reg[1] <= {frame_reg[9], frame_reg[8]};
                mouse_reg[2] <= {frame_reg[11], frame_reg[10]};
                keys_reg     <= {frame_reg[13][0], frame_reg[12][0],
                                 frame_reg[15], frame_reg[14]};
                last_acc_reg <= time_reg;
                seq_reg      <= seq_reg + TIME_W'(1);
            end
        end
    end

    // output register: hold the beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int i = 0; i < NUM_CH; i++)
                out_stick_reg[i] <= stick_reg[i];
            out_switch_reg <= switch_reg;
            for (int i = 0; i < 3; i++)
                out_mouse_reg[i] <= mouse_reg[i];
            out_keys_reg   <= keys_reg;
            out_status_reg <= cmd.status;
            out_link_reg   <= link_now;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stick_ch0        = out_stick_reg[0];
    assign stick_ch1        = out_stick_reg[1];
    assign stick_ch2        = out_stick_reg[2];
    assign stick_ch3        = out_stick_reg[3];
    assign wheel_ch4        = out_stick_reg[4];
    assign switch_pair      = out_switch_reg;
    assign mouse_dx         = out_mouse_reg[0];
    assign mouse_dy         = out_mouse_reg[1];
    assign mouse_dz         = out_mouse_reg[2];
    assign keys_and_buttons = out_keys_reg;
    assign status           = out_status_reg;
    assign link_flags       = out_link_reg;

endmodule

// ----- sv/rc_receiver_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the receiver frame decoder.
// Depends on rcfd_pkg, rcfd_regs, rcfd_ctrl and rcfd_datapath.
//
// Usage:
//   Input beats (op, data_byte) carry received bytes, line idle, millisecond
//   ticks and UART errors over a valid/ready channel. Result beats carry the
//   stored frame, a status code and the link flags over a second valid/ready
//   channel, behind an output register.
//   A received byte gives no result unless it fills the two-frame buffer. A
//   tick or UART error gives its result through the emit state and then the
//   output register, and no new beat is accepted until that result is emitted.
//   A burst end first judges the length, then for each frame reads its 18
//   bytes from the byte buffer, checks the frame and emits its result.
//   No beat is accepted while a burst is being decoded or while a result is
//   held because the receiver stalls; decoding waits for the output register.
//   Reset clears the buffer count, run count, timers and stored frame, and
//   loads the configuration registers with their defaults. The APB-style
//   port writes the registers at byte addresses 0, 4, 8 and 12.

module rc_receiver_frame_decoder_top
    import rcfd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [7:0]              data_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CH_W-1:0]  stick_ch0,
    output logic signed [CH_W-1:0]  stick_ch1,
    output logic signed [CH_W-1:0]  stick_ch2,
    output logic signed [CH_W-1:0]  stick_ch3,
    output logic signed [CH_W-1:0]  wheel_ch4,
    output logic [3:0]              switch_pair,
    output logic signed [15:0]      mouse_dx,
    output logic signed [15:0]      mouse_dy,
    output logic signed [15:0]      mouse_dz,
    output logic [17:0]             keys_and_buttons,
    output logic [2:0]              status,
    output logic [1:0]              link_flags
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op_t'(op)),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcfd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .stick_ch0        (stick_ch0),
        .stick_ch1        (stick_ch1),
        .stick_ch2        (stick_ch2),
        .stick_ch3        (stick_ch3),
        .wheel_ch4        (wheel_ch4),
        .switch_pair      (switch_pair),
        .mouse_dx         (mouse_dx),
        .mouse_dy         (mouse_dy),
        .mouse_dz         (mouse_dz),
        .keys_and_buttons (keys_and_buttons),
        .status           (status),
        .link_flags       (link_flags)
    );

endmodule

// ----- sv/rcfd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the receiver frame decoder, bound to the top level.
// Depends on rcfd_pkg and rc_receiver_frame_decoder_top.

module rcfd_checker
    import rcfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result beat dropped or changed while stalled");

    // no input beat is taken while a result is held back
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input taken while output stalled");

    // a tick is reported by a result beat with tick status after acceptance
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_TICK) |=> ##1 (out_valid && (status == ST_TICK)))
        else $error("tick result missing");

    // a UART error is reported by a result beat with its status after acceptance
    a_uart_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_UART_ERR)
        |=> ##1 (out_valid && (status == ST_UART_ERR)))
        else $error("uart error result missing");

endmodule

bind rc_receiver_frame_decoder_top rcfd_checker u_checker (.*);
